@@ sv/ole_pkg.sv @@
package ole_pkg;

	// fixed port field widths
	localparam int FUNC_W      = 3;
	localparam int INDEX_W     = 6;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 7;

	// parameter defaults
	localparam int DEF_CAPACITY     = 64;
	localparam int DEF_HANDLE_WIDTH = 32;

	// request codes
	localparam logic [FUNC_W-1:0] OP_APPEND   = 3'd0;
	localparam logic [FUNC_W-1:0] OP_REMOVE   = 3'd1;
	localparam logic [FUNC_W-1:0] OP_CONTAINS = 3'd2;
	localparam logic [FUNC_W-1:0] OP_GET      = 3'd3;
	localparam logic [FUNC_W-1:0] OP_CLEAR    = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ sv/ole_mem.sv @@
module ole_mem #(
	parameter int DEPTH = ole_pkg::DEF_CAPACITY,
	parameter int WIDTH = ole_pkg::DEF_HANDLE_WIDTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/ordered_list_engine.sv @@
// ordered list of handles held in a single-port-write, single-port-read memory
// request channel: in_valid/in_ready with func, index, item_value
// result channel: out_valid/out_ready with result_value, found, status, item_count
// one result transaction per request transaction, in request order
// in_ready is high only while the sequencer is idle; one request at a time
// sequencer states after accept, each request then ending in done:
//   append, clear, unused codes, out-of-range get/remove: exec
//   get: exec, get_wait
//   contains: exec, search (one entry compared per cycle, stops at first match)
//   remove: exec, rm_val, shift, one entry moved down per cycle via the memory port
// the sequencer returns to idle as its result is presented, so the next request
// can be accepted while that result is still valid
// the read and write ports of the entry memory and the one address counter
// pace the search and shift steps
// the result sits in an output register; a new request is accepted while it
// waits, and the sequencer holds its finished result until the register frees
// reset (arst_n low) empties the list and drops any pending result; the
// entry memory is not cleared, entries beyond the count are never read
module ordered_list_engine #(
	parameter int CAPACITY     = ole_pkg::DEF_CAPACITY,
	parameter int HANDLE_WIDTH = ole_pkg::DEF_HANDLE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ole_pkg::FUNC_W-1:0]         func,
	input  logic [ole_pkg::INDEX_W-1:0]        index,
	input  logic [ole_pkg::VALUE_W-1:0]        item_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ole_pkg::VALUE_W-1:0]        result_value,
	output logic                               found,
	output logic [ole_pkg::STATUS_W-1:0]       status,
	output logic [ole_pkg::COUNT_OUT_W-1:0]    item_count
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int XW   = (HANDLE_WIDTH > ole_pkg::VALUE_W) ? HANDLE_WIDTH : ole_pkg::VALUE_W;
	localparam int CMPW = ((CW > ole_pkg::INDEX_W) ? CW : ole_pkg::INDEX_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_GET_WAIT,
		S_RM_VAL,
		S_SHIFT,
		S_SEARCH,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [ole_pkg::FUNC_W-1:0]      func_q;
	logic [ole_pkg::INDEX_W-1:0]     pos_q;
	logic [HANDLE_WIDTH-1:0]         handle_q;
	logic [CW-1:0]                   count_q;
	logic [AW-1:0]                   k_q;
	logic [HANDLE_WIDTH-1:0]         value_q;
	logic                            found_q;
	logic [ole_pkg::STATUS_W-1:0]    status_q;
	logic                            out_valid_q;
	logic [ole_pkg::VALUE_W-1:0]     result_q;
	logic                            found_out_q;
	logic [ole_pkg::STATUS_W-1:0]    status_out_q;
	logic [ole_pkg::COUNT_OUT_W-1:0] count_out_q;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [HANDLE_WIDTH-1:0] mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;
	logic [HANDLE_WIDTH-1:0] mem_rdata;

	logic [XW-1:0]           in_ext;
	logic [XW-1:0]           val_ext;
	logic [CMPW-1:0]         pos_ext;
	logic [CMPW-1:0]         cnt_ext;
	logic [CMPW-1:0]         k_ext;
	logic                    in_range;
	logic                    full;
	logic                    k1_below;
	logic                    k2_below;
	logic                    hit;

	assign in_ext   = XW'(item_value);
	assign val_ext  = XW'(value_q);
	assign pos_ext  = CMPW'(pos_q);
	assign cnt_ext  = CMPW'(count_q);
	assign k_ext    = CMPW'(k_q);
	assign in_range = pos_ext < cnt_ext;
	assign full     = count_q == CW'(CAPACITY);
	assign k1_below = (k_ext + CMPW'(1)) < cnt_ext;
	assign k2_below = (k_ext + CMPW'(2)) < cnt_ext;
	assign hit      = mem_rdata == handle_q;

	assign in_ready     = state_q == S_IDLE;
	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign found        = found_out_q;
	assign status       = status_out_q;
	assign item_count   = count_out_q;

	ole_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (HANDLE_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// memory port control, shared by append, shift, search and read
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = handle_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_EXEC: begin
				case (func_q)
					ole_pkg::OP_APPEND: begin
						if (!full) begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
						end
					end
					ole_pkg::OP_REMOVE, ole_pkg::OP_GET: begin
						if (in_range) begin
							mem_re    = 1'b1;
							mem_raddr = pos_ext[AW-1:0];
						end
					end
					ole_pkg::OP_CONTAINS: begin
						mem_re = count_q != '0;
					end
					default: begin
					end
				endcase
			end
			S_RM_VAL: begin
				if (k1_below) begin
					mem_re    = 1'b1;
					mem_raddr = k_q + AW'(1);
				end
			end
			S_SHIFT: begin
				// entry k+1 arrived, store it at k and fetch k+2 if it is inside the list
				mem_we    = 1'b1;
				mem_waddr = k_q;
				mem_wdata = mem_rdata;
				if (k2_below) begin
					mem_re    = 1'b1;
					mem_raddr = k_q + AW'(2);
				end
			end
			S_SEARCH: begin
				if (!hit && k1_below) begin
					mem_re    = 1'b1;
					mem_raddr = k_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q   <= func;
						pos_q    <= index;
						handle_q <= in_ext[HANDLE_WIDTH-1:0];
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= ole_pkg::ST_OK;
					value_q  <= '0;
					found_q  <= 1'b0;
					state_q  <= S_DONE;
					case (func_q)
						ole_pkg::OP_APPEND: begin
							if (full) begin
								status_q <= ole_pkg::ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						ole_pkg::OP_REMOVE: begin
							if (!in_range) begin
								status_q <= ole_pkg::ST_RANGE;
							end else begin
								k_q     <= pos_ext[AW-1:0];
								state_q <= S_RM_VAL;
							end
						end
						ole_pkg::OP_GET: begin
							if (!in_range) begin
								status_q <= ole_pkg::ST_RANGE;
							end else begin
								state_q <= S_GET_WAIT;
							end
						end
						ole_pkg::OP_CONTAINS: begin
							if (count_q != '0) begin
								k_q     <= '0;
								state_q <= S_SEARCH;
							end
						end
						ole_pkg::OP_CLEAR: begin
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_GET_WAIT: begin
					value_q <= mem_rdata;
					state_q <= S_DONE;
				end
				S_RM_VAL: begin
					value_q <= mem_rdata;
					if (k1_below) begin
						state_q <= S_SHIFT;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (k2_below) begin
						k_q <= k_q + AW'(1);
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else if (k1_below) begin
						k_q <= k_q + AW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						result_q     <= val_ext[ole_pkg::VALUE_W-1:0];
						found_out_q  <= found_q;
						status_out_q <= status_q;
						count_out_q  <= ole_pkg::COUNT_OUT_W'(count_q);
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the list never grows past its capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_ext <= CMPW'(CAPACITY))
	else $error("entry count beyond capacity");

	// shifting only touches entries inside the filled range
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> k1_below)
	else $error("shift outside filled range");

	// the entry memory is written only by an active request
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_EXEC || state_q == S_SHIFT))
	else $error("memory write while not busy");

	// a match result carries ok status and no handle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_out_q |-> status_out_q == ole_pkg::ST_OK && result_q == '0)
	else $error("found flag with bad status or value");

	// an accepted request keeps the sequencer busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
	else $error("accepted request not executed");

endmodule
